// ----- sv/cce_pkg.sv -----
// Shared types, command codes and saturation helpers of the crossover equalizer.
package cce_pkg;

  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 32;
  localparam int CoefWidth    = 32;
  localparam int SigWidth     = 32;
  localparam int DlyWidth     = 48;
  localparam int DlyExtra     = 16;
  localparam int WideWidth    = 68;

  localparam logic [CfgIdxWidth-1:0] CfgTrebleGain  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgHighmidGain = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgLowmidGain  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgBassGain    = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgHighPole    = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CfgMidPole     = 3'd5;
  localparam logic [CfgIdxWidth-1:0] CfgLowPole     = 3'd6;

  localparam logic [1:0] BandHigh = 2'd0;
  localparam logic [1:0] BandMid  = 2'd1;
  localparam logic [1:0] BandLow  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BQ_MUL_A0,
    ST_BQ_P,
    ST_BQ_Y,
    ST_BQ_MUL_B1,
    ST_BQ_S0,
    ST_BQ_MUL_B2,
    ST_BQ_S1,
    ST_MIX_MUL,
    ST_MIX_END,
    ST_PL_D,
    ST_PL_MUL_HI,
    ST_PL_MUL_LO,
    ST_PL_SUM,
    ST_PL_UPD,
    ST_PL_OUT,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_COEF,
    OP_LOAD,
    OP_BQ_MUL_A0,
    OP_BQ_P,
    OP_BQ_Y,
    OP_BQ_MUL_B1,
    OP_BQ_S0,
    OP_BQ_MUL_B2,
    OP_BQ_S1,
    OP_MIX_MUL,
    OP_MIX_END,
    OP_PL_D,
    OP_PL_MUL_HI,
    OP_PL_MUL_LO,
    OP_PL_SUM,
    OP_PL_UPD,
    OP_PL_OUT,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] band;
    logic [3:0] filt;
    logic [1:0] mix;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } status_t;

  function automatic logic signed [DlyWidth-1:0] sat48(input logic signed [WideWidth-1:0] v);
    if (v[WideWidth-1:DlyWidth-1] == {(WideWidth-DlyWidth+1){v[WideWidth-1]}}) begin
      return v[DlyWidth-1:0];
    end
    return v[WideWidth-1] ? {1'b1, {(DlyWidth-1){1'b0}}} : {1'b0, {(DlyWidth-1){1'b1}}};
  endfunction

  function automatic logic signed [SigWidth-1:0] sat32(input logic signed [WideWidth-1:0] v);
    if (v[WideWidth-1:SigWidth-1] == {(WideWidth-SigWidth+1){v[WideWidth-1]}}) begin
      return v[SigWidth-1:0];
    end
    return v[WideWidth-1] ? {1'b1, {(SigWidth-1){1'b0}}} : {1'b0, {(SigWidth-1){1'b1}}};
  endfunction

endpackage

// ----- sv/cce_if.sv -----
// Handshake interfaces of the sample input, result output and configuration channels.
interface cce_in_if #(
  parameter int SampleWidth = 24
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [4:0]                    coef_index;
  logic signed [31:0]            coef_value;
  logic signed [SampleWidth-1:0] sample_in;

  modport source (output valid, kind, coef_index, coef_value, sample_in, input ready);
  modport sink (input valid, kind, coef_index, coef_value, sample_in, output ready);
endinterface

interface cce_out_if #(
  parameter int SampleWidth = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

interface cce_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/cce_ctrl.sv -----
// Sequencer that steps the shared datapath through all filters and mixes of one sample.
module cce_ctrl
  import cce_pkg::*;
#(
  parameter int BiquadStages = 3
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_kind_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [3:0] LastFilt = 4'(3 * BiquadStages - 1);

  ctrl_state_e state_q, state_d;
  logic [1:0]  band_q, band_d;
  logic [3:0]  filt_q, filt_d;
  logic [1:0]  mix_q, mix_d;
  logic        pole_q, pole_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      band_q  <= '0;
      filt_q  <= '0;
      mix_q   <= '0;
      pole_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      band_q  <= band_d;
      filt_q  <= filt_d;
      mix_q   <= mix_d;
      pole_q  <= pole_d;
    end
  end

  always_comb begin
    state_d = state_q;
    band_d  = band_q;
    filt_d  = filt_q;
    mix_d   = mix_q;
    pole_d  = pole_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_kind_i) begin
          state_d = ST_BQ_MUL_A0;
          band_d  = BandHigh;
          filt_d  = '0;
          pole_d  = 1'b0;
        end
      end
      ST_BQ_MUL_A0: state_d = ST_BQ_P;
      ST_BQ_P:      state_d = ST_BQ_Y;
      ST_BQ_Y:      state_d = ST_BQ_MUL_B1;
      ST_BQ_MUL_B1: state_d = ST_BQ_S0;
      ST_BQ_S0:     state_d = ST_BQ_MUL_B2;
      ST_BQ_MUL_B2: state_d = ST_BQ_S1;
      ST_BQ_S1: begin
        if (band_q == BandLow) begin
          state_d = ST_MIX_MUL;
          mix_d   = '0;
        end else begin
          state_d = ST_BQ_MUL_A0;
          band_d  = band_q + 2'd1;
          filt_d  = filt_q + 4'd1;
        end
      end
      ST_MIX_MUL: begin
        mix_d = mix_q + 2'd1;
        if (mix_q == 2'd3) begin
          state_d = ST_MIX_END;
        end
      end
      ST_MIX_END: begin
        band_d = BandHigh;
        if (pole_q) begin
          state_d = ST_OUT;
        end else if (filt_q == LastFilt) begin
          state_d = ST_PL_D;
          pole_d  = 1'b1;
        end else begin
          state_d = ST_BQ_MUL_A0;
          filt_d  = filt_q + 4'd1;
        end
      end
      ST_PL_D:      state_d = ST_PL_MUL_HI;
      ST_PL_MUL_HI: state_d = ST_PL_MUL_LO;
      ST_PL_MUL_LO: state_d = ST_PL_SUM;
      ST_PL_SUM:    state_d = ST_PL_UPD;
      ST_PL_UPD:    state_d = ST_PL_OUT;
      ST_PL_OUT: begin
        if (band_q == BandLow) begin
          state_d = ST_MIX_MUL;
          mix_d   = '0;
        end else begin
          state_d = ST_PL_D;
          band_d  = band_q + 2'd1;
        end
      end
      ST_OUT: begin
        if (!status_i.out_stall) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    cmd_o.band  = band_q;
    cmd_o.filt  = filt_q;
    cmd_o.mix   = mix_q;
    cmd_o.op    = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = in_kind_i ? OP_LOAD : OP_COEF;
        end
      end
      ST_BQ_MUL_A0: cmd_o.op = OP_BQ_MUL_A0;
      ST_BQ_P:      cmd_o.op = OP_BQ_P;
      ST_BQ_Y:      cmd_o.op = OP_BQ_Y;
      ST_BQ_MUL_B1: cmd_o.op = OP_BQ_MUL_B1;
      ST_BQ_S0:     cmd_o.op = OP_BQ_S0;
      ST_BQ_MUL_B2: cmd_o.op = OP_BQ_MUL_B2;
      ST_BQ_S1:     cmd_o.op = OP_BQ_S1;
      ST_MIX_MUL:   cmd_o.op = OP_MIX_MUL;
      ST_MIX_END:   cmd_o.op = OP_MIX_END;
      ST_PL_D:      cmd_o.op = OP_PL_D;
      ST_PL_MUL_HI: cmd_o.op = OP_PL_MUL_HI;
      ST_PL_MUL_LO: cmd_o.op = OP_PL_MUL_LO;
      ST_PL_SUM:    cmd_o.op = OP_PL_SUM;
      ST_PL_UPD:    cmd_o.op = OP_PL_UPD;
      ST_PL_OUT:    cmd_o.op = OP_PL_OUT;
      ST_OUT:       cmd_o.op = status_i.out_stall ? OP_NONE : OP_OUT;
      default:      cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ----- sv/cce_datapath.sv -----
// Shared multiplier, filter state, coefficient store, band registers and output register.
module cce_datapath
  import cce_pkg::*;
#(
  parameter int SampleWidth  = 24,
  parameter int CoefFracBits = 28,
  parameter int BiquadStages = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cmd_t                          cmd_i,
  output status_t                       status_o,
  input  logic [4:0]                    coef_index_i,
  input  logic signed [CoefWidth-1:0]   coef_value_i,
  input  logic signed [SampleWidth-1:0] sample_in_i,
  input  logic                          cfg_we_i,
  input  logic [CfgIdxWidth-1:0]        cfg_index_i,
  input  logic [CfgDataWidth-1:0]       cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SampleWidth-1:0] sample_out_o
);

  localparam int SigFrac  = (32 - SampleWidth) / 2;
  localparam int ProdSh   = CoefFracBits - DlyExtra;
  localparam int NumFilt  = 3 * BiquadStages;
  localparam int FiltW    = $clog2(NumFilt);
  localparam int NumSlots = 9 * BiquadStages;
  localparam int GainW    = 30;
  localparam int PoleW    = 28;
  localparam int MulAW    = 34;
  localparam int MulBW    = 33;
  localparam int ProdW    = MulAW + MulBW;
  localparam int AccW     = 66;
  localparam int DiffW    = DlyWidth + 1;
  localparam int PoleMW   = DlyWidth + 2;

  logic signed [CoefWidth-1:0] a0_q [NumFilt];
  logic signed [CoefWidth-1:0] b1_q [NumFilt];
  logic signed [CoefWidth-1:0] b2_q [NumFilt];
  logic signed [DlyWidth-1:0]  s0_q [NumFilt];
  logic signed [DlyWidth-1:0]  s1_q [NumFilt];
  logic signed [DlyWidth-1:0]  ps_q [3];

  logic [GainW-1:0] treble_q, highmid_q, lowmid_q, bass_q;
  logic [PoleW-1:0] hpole_q, mpole_q, lpole_q;

  logic signed [SigWidth-1:0] w_q [4];
  logic signed [SigWidth-1:0] w_d [4];
  logic signed [SigWidth-1:0] tr_q, tr_d, y_q, y_d;
  logic signed [DlyWidth-1:0] p_q, p_d;
  logic signed [ProdW-1:0]    prod_q, prod_d, a_q, a_d;
  logic signed [AccW-1:0]     acc_q, acc_d;
  logic signed [DiffW-1:0]    dd_q, dd_d;
  logic signed [PoleMW-1:0]   m_q, m_d;
  logic                       out_valid_q;
  logic signed [SampleWidth-1:0] out_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;

  logic [FiltW-1:0]            fi;
  logic signed [SigWidth-1:0]  sel_in, diff, shifted;
  logic signed [DlyWidth-1:0]  xd, ps_new, q_val, yd;
  logic [PoleW-1:0]            pole_c;
  logic signed [DlyWidth-1:0]  s0_new, s1_new;
  logic                        s0_we, s1_we, ps_we, out_we;
  logic signed [SampleWidth-1:0] out_d;

  logic [8:0]       slot_f9;
  logic [4:0]       slot_f;
  logic [4:0]       slot_k;
  logic [5:0]       slot_base;

  assign fi     = cmd_i.filt[FiltW-1:0];
  assign sel_in = w_q[cmd_i.band];
  assign xd     = DlyWidth'(sel_in) <<< DlyExtra;
  assign mul_p  = mul_a * mul_b;

  // Slots beyond the reach of the coefficient index read as zero.
  assign slot_base = 6'(fi) * 6'd3;

  always_comb begin
    unique case (cmd_i.band)
      BandHigh: pole_c = hpole_q;
      BandMid:  pole_c = mpole_q;
      default:  pole_c = lpole_q;
    endcase
  end

  // Slot number split into filter and coefficient by a reciprocal multiply.
  assign slot_f9 = 9'(coef_index_i) * 9'd11;
  assign slot_f  = 5'(slot_f9 >> 5);
  assign slot_k  = coef_index_i - 5'(slot_f * 5'd3);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w_d[i] = w_q[i];
    end
    tr_d   = tr_q;
    y_d    = y_q;
    p_d    = p_q;
    prod_d = prod_q;
    a_d    = a_q;
    acc_d  = acc_q;
    dd_d   = dd_q;
    m_d    = m_q;
    mul_a  = '0;
    mul_b  = '0;
    yd     = '0;
    q_val  = '0;
    ps_new = '0;
    diff   = '0;
    s0_new = '0;
    s1_new = '0;
    s0_we  = 1'b0;
    s1_we  = 1'b0;
    ps_we  = 1'b0;
    out_we = 1'b0;
    shifted = w_q[0] >>> SigFrac;
    out_d   = SampleWidth'(shifted);
    if (shifted[SigWidth-1:SampleWidth-1] != {(SigWidth-SampleWidth+1){shifted[SigWidth-1]}})
    begin
      out_d = shifted[SigWidth-1] ? {1'b1, {(SampleWidth-1){1'b0}}}
                                  : {1'b0, {(SampleWidth-1){1'b1}}};
    end
    case (cmd_i.op) inside
      OP_LOAD: w_d[0] = SigWidth'(sample_in_i) <<< SigFrac;
      OP_BQ_MUL_A0: begin
        mul_a  = (slot_base < 6'd32) ? MulAW'(a0_q[fi]) : '0;
        mul_b  = MulBW'(sel_in);
        prod_d = mul_p;
      end
      OP_BQ_P: p_d = sat48(WideWidth'(prod_q >>> ProdSh));
      OP_BQ_Y: begin
        yd  = sat48(WideWidth'(p_q) + WideWidth'(s0_q[fi]));
        y_d = sat32(WideWidth'(yd >>> DlyExtra));
      end
      OP_BQ_MUL_B1: begin
        mul_a  = (slot_base < 6'd31) ? MulAW'(b1_q[fi]) : '0;
        mul_b  = MulBW'(y_q);
        prod_d = mul_p;
      end
      OP_BQ_S0: begin
        q_val  = sat48(WideWidth'(prod_q >>> ProdSh));
        s0_new = sat48((WideWidth'(p_q) <<< 1) - WideWidth'(q_val) + WideWidth'(s1_q[fi]));
        s0_we  = 1'b1;
      end
      OP_BQ_MUL_B2: begin
        mul_a  = (slot_base < 6'd30) ? MulAW'(b2_q[fi]) : '0;
        mul_b  = MulBW'(y_q);
        prod_d = mul_p;
      end
      OP_BQ_S1, OP_PL_OUT: begin
        if (cmd_i.op == OP_BQ_S1) begin
          q_val  = sat48(WideWidth'(prod_q >>> ProdSh));
          s1_new = sat48(WideWidth'(p_q) - WideWidth'(q_val));
          s1_we  = 1'b1;
        end
        diff = sat32(WideWidth'(sel_in) - WideWidth'(y_q));
        w_d[cmd_i.band + 2'd1] = y_q;
        if (cmd_i.band == BandHigh) begin
          tr_d = diff;
        end else begin
          w_d[cmd_i.band] = diff;
        end
      end
      OP_MIX_MUL: begin
        case (cmd_i.mix)
          2'd0: begin
            mul_a = MulAW'(bass_q);
            mul_b = MulBW'(w_q[3]);
          end
          2'd1: begin
            mul_a = MulAW'(lowmid_q);
            mul_b = MulBW'(w_q[2]);
          end
          2'd2: begin
            mul_a = MulAW'(highmid_q);
            mul_b = MulBW'(w_q[1]);
          end
          default: begin
            mul_a = MulAW'(treble_q);
            mul_b = MulBW'(tr_q);
          end
        endcase
        prod_d = mul_p;
        acc_d  = (cmd_i.mix == 2'd0) ? '0 : acc_q + AccW'(prod_q);
      end
      OP_MIX_END: w_d[0] = sat32(WideWidth'((acc_q + AccW'(prod_q)) >>> CoefFracBits));
      OP_PL_D: dd_d = DiffW'(ps_q[cmd_i.band]) - DiffW'(xd);
      OP_PL_MUL_HI: begin
        mul_a  = MulAW'(dd_q >>> DlyExtra);
        mul_b  = MulBW'(pole_c);
        prod_d = mul_p;
      end
      OP_PL_MUL_LO: begin
        a_d    = prod_q;
        mul_a  = MulAW'(dd_q[DlyExtra-1:0]);
        mul_b  = MulBW'(pole_c);
        prod_d = mul_p;
      end
      OP_PL_SUM: m_d = PoleMW'((WideWidth'(a_q) + WideWidth'(prod_q >>> DlyExtra))
                              >>> ProdSh);
      OP_PL_UPD: begin
        ps_new = sat48(WideWidth'(xd) + WideWidth'(m_q));
        ps_we  = 1'b1;
        y_d    = sat32(WideWidth'(ps_new >>> DlyExtra));
      end
      OP_OUT: out_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumFilt; i++) begin
        s0_q[i] <= '0;
        s1_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        ps_q[i] <= '0;
      end
      treble_q    <= GainW'(1) << CoefFracBits;
      highmid_q   <= GainW'(1) << CoefFracBits;
      lowmid_q    <= GainW'(1) << CoefFracBits;
      bass_q      <= GainW'(1) << CoefFracBits;
      hpole_q     <= '0;
      mpole_q     <= '0;
      lpole_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s0_we) begin
        s0_q[fi] <= s0_new;
      end
      if (s1_we) begin
        s1_q[fi] <= s1_new;
      end
      if (ps_we) begin
        ps_q[cmd_i.band] <= ps_new;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgTrebleGain:  treble_q  <= cfg_data_i[GainW-1:0];
          CfgHighmidGain: highmid_q <= cfg_data_i[GainW-1:0];
          CfgLowmidGain:  lowmid_q  <= cfg_data_i[GainW-1:0];
          CfgBassGain:    bass_q    <= cfg_data_i[GainW-1:0];
          CfgHighPole:    hpole_q   <= cfg_data_i[PoleW-1:0];
          CfgMidPole:     mpole_q   <= cfg_data_i[PoleW-1:0];
          CfgLowPole:     lpole_q   <= cfg_data_i[PoleW-1:0];
          default: ;
        endcase
      end
      if (out_we) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      w_q[i] <= w_d[i];
    end
    tr_q   <= tr_d;
    y_q    <= y_d;
    p_q    <= p_d;
    prod_q <= prod_d;
    a_q    <= a_d;
    acc_q  <= acc_d;
    dd_q   <= dd_d;
    m_q    <= m_d;
    if (out_we) begin
      out_q <= out_d;
    end
    if (cmd_i.op == OP_COEF && 32'(coef_index_i) < NumSlots) begin
      case (slot_k)
        5'd0:    a0_q[slot_f[FiltW-1:0]] <= coef_value_i;
        5'd1:    b1_q[slot_f[FiltW-1:0]] <= coef_value_i;
        default: b2_q[slot_f[FiltW-1:0]] <= coef_value_i;
      endcase
    end
  end

  assign status_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign sample_out_o       = out_q;

endmodule

// ----- sv/cascaded_crossover_equalizer_top.sv -----
// Top level of the four-band cascaded crossover equalizer.
// A coefficient load transaction is written while the sequencer stays idle; an audio transaction
// holds off the input until its result is registered, paced by the one shared multiplier
// that runs every biquad, one-pole and gain product in turn.
// Reset clears filter states, gains to unity and poles to zero; coefficients are unset.
module cascaded_crossover_equalizer_top
  import cce_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 28,
  parameter int BIQUAD_STAGES  = 3
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  cce_in_if.sink    in_if,
  cce_out_if.source out_if,
  cce_cfg_if.sink   cfg_if
);

  cmd_t    cmd;
  status_t status;

  assign cfg_if.ready = 1'b1;

  cce_ctrl #(
    .BiquadStages(BIQUAD_STAGES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_kind_i  (in_if.kind),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cce_datapath #(
    .SampleWidth (SAMPLE_WIDTH),
    .CoefFracBits(COEF_FRAC_BITS),
    .BiquadStages(BIQUAD_STAGES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .coef_index_i (in_if.coef_index),
    .coef_value_i (in_if.coef_value),
    .sample_in_i  (in_if.sample_in),
    .cfg_we_i     (cfg_if.valid),
    .cfg_index_i  (cfg_if.index),
    .cfg_data_i   (cfg_if.data),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .sample_out_o (out_if.sample_out)
  );

endmodule

// ----- bench/cce_checker.sv -----
// Checker that predicts equalized samples from observed transactions and compares the results.
`timescale 1ns / 1ps
module cce_checker
  import cce_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 28,
  parameter int BIQUAD_STAGES  = 3
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  logic in_kind_i,
  input  logic [4:0] in_coef_index_i,
  input  logic signed [31:0] in_coef_value_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  logic signed [SAMPLE_WIDTH-1:0] out_sample_i,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int SigFrac   = (32 - SAMPLE_WIDTH) / 2;
  localparam int Slots     = 9 * BIQUAD_STAGES;
  localparam int Filters   = 3 * BIQUAD_STAGES;
  localparam int SplitBits = 16;

  longint gain_tr, gain_hm, gain_lm, gain_bs;
  longint pole_coef [3];
  longint coefs [Slots];
  longint delay_line [2*Filters];
  longint pole_acc [3];
  logic signed [SAMPLE_WIDTH-1:0] expected_samples [$];
  int mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_samples.size();

  function automatic longint clamp(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint run_biquad(int f, longint x);
    longint p, yd, y, q1, q2;
    int sh;
    sh = COEF_FRAC_BITS - DlyExtra;
    p  = clamp(floor_shift(coefs[3*f] * x, sh), 48);
    yd = clamp(p + delay_line[2*f], 48);
    y  = clamp(floor_shift(yd, DlyExtra), 32);
    q1 = clamp(floor_shift(coefs[3*f+1] * y, sh), 48);
    q2 = clamp(floor_shift(coefs[3*f+2] * y, sh), 48);
    delay_line[2*f]   = clamp(2 * p - q1 + delay_line[2*f+1], 48);
    delay_line[2*f+1] = clamp(p - q2, 48);
    return y;
  endfunction

  function automatic longint run_pole(int i, longint c, longint x);
    longint xd, d, hi, lo, prod;
    xd = x * (longint'(1) <<< DlyExtra);
    d  = pole_acc[i] - xd;
    hi = floor_shift(d, SplitBits);
    lo = d - hi * (longint'(1) <<< SplitBits);
    prod = floor_shift(hi * c + floor_shift(lo * c, SplitBits), COEF_FRAC_BITS - SplitBits);
    pole_acc[i] = clamp(xd + prod, 48);
    return clamp(floor_shift(pole_acc[i], DlyExtra), 32);
  endfunction

  function automatic longint band_mix(longint bs, longint lm, longint hm, longint tr);
    longint acc;
    acc = gain_bs * bs + gain_lm * lm + gain_hm * hm + gain_tr * tr;
    return clamp(floor_shift(acc, COEF_FRAC_BITS), 32);
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] equalize(longint s);
    longint x, hm, lm, bs, tr;
    x = s * (longint'(1) <<< SigFrac);
    for (int st = 0; st < BIQUAD_STAGES; st++) begin
      hm = run_biquad(3*st, x);
      tr = clamp(x - hm, 32);
      lm = run_biquad(3*st+1, hm);
      hm = clamp(hm - lm, 32);
      bs = run_biquad(3*st+2, lm);
      lm = clamp(lm - bs, 32);
      x  = band_mix(bs, lm, hm, tr);
    end
    hm = run_pole(0, pole_coef[0], x);
    tr = clamp(x - hm, 32);
    lm = run_pole(1, pole_coef[1], hm);
    hm = clamp(hm - lm, 32);
    bs = run_pole(2, pole_coef[2], lm);
    lm = clamp(lm - bs, 32);
    x  = band_mix(bs, lm, hm, tr);
    return SAMPLE_WIDTH'(clamp(floor_shift(x, SigFrac), SAMPLE_WIDTH));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_tr = longint'(1) <<< COEF_FRAC_BITS;
      gain_hm = gain_tr;
      gain_lm = gain_tr;
      gain_bs = gain_tr;
      foreach (pole_coef[i]) pole_coef[i] = 0;
      foreach (pole_acc[i]) pole_acc[i] = 0;
      foreach (coefs[i]) coefs[i] = 0;
      foreach (delay_line[i]) delay_line[i] = 0;
      expected_samples.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgTrebleGain:  gain_tr = longint'(cfg_data_i[29:0]);
          CfgHighmidGain: gain_hm = longint'(cfg_data_i[29:0]);
          CfgLowmidGain:  gain_lm = longint'(cfg_data_i[29:0]);
          CfgBassGain:    gain_bs = longint'(cfg_data_i[29:0]);
          CfgHighPole:    pole_coef[0] = longint'(cfg_data_i[27:0]);
          CfgMidPole:     pole_coef[1] = longint'(cfg_data_i[27:0]);
          CfgLowPole:     pole_coef[2] = longint'(cfg_data_i[27:0]);
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (!in_kind_i) begin
          if (in_coef_index_i < Slots) coefs[in_coef_index_i] = longint'(in_coef_value_i);
        end else begin
          expected_samples.push_back(equalize(longint'(in_sample_i)));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %0d.", out_sample_i);
        end else begin
          if (out_sample_i !== expected_samples[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %0d, got %0d.", expected_samples[0], out_sample_i);
          end
          void'(expected_samples.pop_front());
        end
      end
    end
  end

endmodule

// ----- bench/cascaded_crossover_equalizer_top_tb.sv -----
// Testbench top that drives coefficient, sample and register transactions and gives the verdict.
`timescale 1ns / 1ps
module cascaded_crossover_equalizer_top_tb
  import cce_pkg::*;
();

  localparam int SW = 24;
  localparam int Latency = 26 * 3 + 30;
  localparam longint CycleLimit = 1200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int fail_count, pending;
  longint cycles = 0;
  logic idle_out;
  logic [4:0] stall_left;

  cce_in_if #(.SampleWidth(SW)) in_if ();
  cce_out_if #(.SampleWidth(SW)) out_if ();
  cce_cfg_if cfg_if ();

  always #5 clk_i = ~clk_i;

  cascaded_crossover_equalizer_top u_top (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_if (in_if), .out_if (out_if), .cfg_if (cfg_if)
  );

  cce_checker u_checker (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .in_valid_i (in_if.valid), .in_ready_i (in_if.ready), .in_kind_i (in_if.kind),
    .in_coef_index_i (in_if.coef_index), .in_coef_value_i (in_if.coef_value),
    .in_sample_i (in_if.sample_in),
    .out_valid_i (out_if.valid), .out_ready_i (out_if.ready), .out_sample_i (out_if.sample_out),
    .cfg_valid_i (cfg_if.valid), .cfg_ready_i (cfg_if.ready), .cfg_index_i (cfg_if.index),
    .cfg_data_i (cfg_if.data), .fail_count_o (fail_count), .pending_o (pending)
  );

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = 1'b0;
    in_if.coef_index = '0;
    in_if.coef_value = '0;
    in_if.sample_in = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[cascaded_crossover_equalizer_top] ERROR");
      $finish;
    end
  end

  // Result-side back pressure: mostly short stalls, sometimes long ones, some quiet stretches.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 5'd1;
      out_if.ready <= 1'b0;
    end else if (!idle_out && $urandom_range(0, 3) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? 5'($urandom_range(8, 30))
                                                : 5'($urandom_range(0, 3));
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    stall_left = '0;
    idle_out = 1'b0;
    forever begin
      repeat (500) @(posedge clk_i);
      idle_out = ($urandom_range(0, 2) == 0);
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 60))
                                       : int'($urandom_range(0, 2));
  endfunction

  // Valid stays high when the next transaction follows at once.
  task automatic send_item(logic kind, logic [4:0] idx, logic [31:0] val,
                           logic [SW-1:0] smp, bit gap);
    int n;
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.coef_index <= idx;
    in_if.coef_value <= val;
    in_if.sample_in <= smp;
    do @(posedge clk_i); while (!in_if.ready);
    n = gap ? gap_len() : 0;
    if (n != 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  // Stable lowpass-like coefficients with random spread, or fully random ones when wild, written to every slot.
  task automatic load_filters(bit wild);
    logic [31:0] v;
    for (int s = 0; s < 27; s++) begin
      case (s % 3)
        0: v = wild ? $urandom : 32'($urandom_range(0, 32'h0200_0000));
        1: v = wild ? $urandom : 32'(-$urandom_range(32'h1000_0000, 32'h1E00_0000));
        default: v = wild ? $urandom : 32'($urandom_range(32'h0400_0000, 32'h0E00_0000));
      endcase
      send_item(1'b0, 5'(s), v, '0, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic write_gains(logic [31:0] tr, logic [31:0] hm, logic [31:0] lm,
                             logic [31:0] bs);
    write_reg(CfgTrebleGain, tr);
    write_reg(CfgHighmidGain, hm);
    write_reg(CfgLowmidGain, lm);
    write_reg(CfgBassGain, bs);
  endtask

  task automatic write_poles(logic [31:0] h, logic [31:0] m, logic [31:0] l);
    write_reg(CfgHighPole, h);
    write_reg(CfgMidPole, m);
    write_reg(CfgLowPole, l);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(SW-1){1'b1}}};
      1: return {1'b1, {(SW-1){1'b0}}};
      default: return SW'($urandom);
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_filters(1'b0);
    send_item(1'b1, '0, '0, {1'b0, {(SW-1){1'b1}}}, 1'b1);
    send_item(1'b1, '0, '0, {1'b1, {(SW-1){1'b0}}}, 1'b1);
    send_item(1'b1, '0, '0, '0, 1'b1);
    send_item(1'b1, '0, '0, '1, 1'b1);
    send_item(1'b0, 5'd27, 32'hFFFF_FFFF, '0, 1'b1);
    send_item(1'b0, 5'd31, 32'h8000_0000, '0, 1'b1);
    send_item(1'b0, 5'd0, 32'h7FFF_FFFF, '0, 1'b1);
    send_item(1'b0, 5'd1, 32'h8000_0000, '0, 1'b1);
    send_item(1'b1, '0, '0, {1'b0, {(SW-1){1'b1}}}, 1'b1);
    send_item(1'b1, '0, '0, {1'b1, {(SW-1){1'b0}}}, 1'b1);
    send_item(1'b1, '0, '0, 24'h55AAAA, 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_gains(32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000);
                 write_poles(32'h0FFF_FFFF, 32'h0FFF_FFFF, 32'h0FFF_FFFF); end
        1: begin write_gains('0, '0, '0, '0); write_poles('0, '0, '0); end
        2: begin write_gains(32'hFFFF_FFFF, 32'h1000_0000, '0, 32'hC000_0000);
                 write_poles(32'hF000_0000, 32'h0800_0000, 32'h0123_4567); end
        default: begin
          write_gains($urandom_range(0, 32'h2000_0000), $urandom_range(0, 32'h2000_0000),
                      $urandom_range(0, 32'h2000_0000), $urandom_range(0, 32'h2000_0000));
          write_poles($urandom, $urandom, $urandom);
        end
      endcase
      load_filters(ph == 2 || ph == 5);
      for (int n = 0; n < 170; n++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(1'b0, 5'($urandom), $urandom, SW'($urandom), 1'b1);
        else
          send_item(1'b1, 5'($urandom), $urandom, pick_sample(), $urandom_range(0, 3) != 0);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("[cascaded_crossover_equalizer_top] OK");
    end else begin
      $display("[cascaded_crossover_equalizer_top] ERROR");
    end
    $finish;
  end

endmodule
